// ===== design/stack_machine_execute_unit_core_defines.svh =====
// ----------------------------------------------------------------------------
// stack machine execute unit assertion macros
// shared property forms for the assertion blocks
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTE_UNIT_CORE_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_UNIT_CORE_DEFINES_SVH

// same-cycle implication
`define SMEU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMEU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/smeu_pkg.sv =====
// ----------------------------------------------------------------------------
// smeu_pkg
// types, opcodes and sizes shared by the stack machine execute unit
// ----------------------------------------------------------------------------
package smeu_pkg;

    localparam int DSTACK_DEPTH = 64;
    localparam int DS_AW        = $clog2(DSTACK_DEPTH);
    localparam int SP_W         = DS_AW + 1;
    localparam int CSTACK_DEPTH = 32;
    localparam int CS_AW        = $clog2(CSTACK_DEPTH);
    localparam int CSP_W        = CS_AW + 1;
    localparam int MEM_DEPTH    = 4096;
    localparam int MEM_AW       = $clog2(MEM_DEPTH);
    localparam int LIM_W        = 17;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [7:0] OP_NOP    = 8'h00;
    localparam logic [7:0] OP_ADD    = 8'h10;
    localparam logic [7:0] OP_SUB    = 8'h11;
    localparam logic [7:0] OP_MUL    = 8'h12;
    localparam logic [7:0] OP_DIV    = 8'h13;
    localparam logic [7:0] OP_REM    = 8'h14;
    localparam logic [7:0] OP_NEG    = 8'h15;
    localparam logic [7:0] OP_AND    = 8'h16;
    localparam logic [7:0] OP_OR     = 8'h17;
    localparam logic [7:0] OP_XOR    = 8'h18;
    localparam logic [7:0] OP_SHL    = 8'h19;
    localparam logic [7:0] OP_SHRA   = 8'h1a;
    localparam logic [7:0] OP_SHRL   = 8'h1b;
    localparam logic [7:0] OP_GOTO   = 8'h30;
    localparam logic [7:0] OP_CALL   = 8'h31;
    localparam logic [7:0] OP_BEQ    = 8'h32;
    localparam logic [7:0] OP_BNE    = 8'h33;
    localparam logic [7:0] OP_BLT    = 8'h34;
    localparam logic [7:0] OP_BGE    = 8'h35;
    localparam logic [7:0] OP_BGT    = 8'h36;
    localparam logic [7:0] OP_BLE    = 8'h37;
    localparam logic [7:0] OP_RET    = 8'h40;
    localparam logic [7:0] OP_BIPUSH = 8'h50;
    localparam logic [7:0] OP_IPUSH  = 8'h51;
    localparam logic [7:0] OP_POP    = 8'h53;
    localparam logic [7:0] OP_DUP    = 8'h54;
    localparam logic [7:0] OP_DUPX1  = 8'h55;
    localparam logic [7:0] OP_DUP2   = 8'h56;
    localparam logic [7:0] OP_SWAP   = 8'h57;
    localparam logic [7:0] OP_LOAD   = 8'h60;
    localparam logic [7:0] OP_STORE  = 8'h61;
    localparam logic [7:0] OP_LDX0   = 8'h62;
    localparam logic [7:0] OP_STX0   = 8'h63;
    localparam logic [7:0] OP_LDX1   = 8'h64;
    localparam logic [7:0] OP_STX1   = 8'h65;
    localparam logic [7:0] OP_LDX2   = 8'h66;
    localparam logic [7:0] OP_STX2   = 8'h67;
    localparam logic [7:0] OP_LPUSH  = 8'h69;
    localparam logic [7:0] OP_HALT   = 8'hf0;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_HALT  = 3'd1;
    localparam logic [2:0] ST_UNDER = 3'd2;
    localparam logic [2:0] ST_OVER  = 3'd3;
    localparam logic [2:0] ST_ADDR  = 3'd4;
    localparam logic [2:0] ST_DIV0  = 3'd5;
    localparam logic [2:0] ST_UNSUP = 3'd6;
    localparam logic [2:0] ST_CALL  = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_MEM_WORDS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_BYTES = 2'd1;

    localparam logic [1:0] RD_A   = 2'd0;
    localparam logic [1:0] RD_B   = 2'd1;
    localparam logic [1:0] RD_C   = 2'd2;
    localparam logic [1:0] RD_TOP = 2'd3;

    typedef struct packed {
        logic [7:0]         opcode;
        logic signed [31:0] immediate;
        logic [15:0]        pc;
    } smeu_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] next_pc;
        logic [31:0] top_value;
        logic [6:0]  stack_depth;
    } smeu_out_t;

    typedef struct packed {
        logic       load;
        logic [1:0] rd_sel;
        logic       cap_a;
        logic       cap_b;
        logic       exec;
        logic       disp;
        logic       div_start;
        logic       div_cap;
        logic       wr;
        logic [1:0] widx;
        logic       top_cap;
    } smeu_cmd_t;

    typedef struct packed {
        logic       need_div;
        logic [1:0] wcnt;
        logic       div_done;
    } smeu_sts_t;

endpackage

// ===== design/smeu_div.sv =====
// ----------------------------------------------------------------------------
// smeu_div
// unsigned 32-bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module smeu_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quot,
    output logic [31:0] rem
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [32:0] trial;
    logic        ge;

    assign trial = {r_reg, q_reg[31]} - {1'b0, d_reg};
    assign ge    = !trial[32];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            q_next    = dividend;
            r_next    = 32'd0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            r_next   = ge ? trial[31:0] : {r_reg[30:0], q_reg[31]};
            q_next   = {q_reg[30:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;
endmodule

// ===== design/smeu_ctrl.sv =====
// ----------------------------------------------------------------------------
// smeu_ctrl
// sequencer for operand reads, execute, divide, stack writes and result
// ----------------------------------------------------------------------------
module smeu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                instr_valid,
    output logic                instr_stall,
    output logic                result_valid,
    input  logic                result_stall,
    input  smeu_pkg::smeu_sts_t sts,
    output smeu_pkg::smeu_cmd_t cmd
);
    import smeu_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RA   = 4'd1;
    localparam logic [3:0] S_RB   = 4'd2;
    localparam logic [3:0] S_RC   = 4'd3;
    localparam logic [3:0] S_EX   = 4'd4;
    localparam logic [3:0] S_DISP = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_WR   = 4'd7;
    localparam logic [3:0] S_TOP  = 4'd8;
    localparam logic [3:0] S_TOPC = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [1:0] widx_reg, widx_next;

    always_comb
    begin
        state_next = state_reg;
        widx_next  = widx_reg;
        cmd        = '0;
        cmd.rd_sel = RD_A;
        cmd.widx   = widx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (instr_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RA;
                end
            end
            S_RA:
            begin
                cmd.rd_sel = RD_A;
                state_next = S_RB;
            end
            S_RB:
            begin
                cmd.rd_sel = RD_B;
                cmd.cap_a  = 1'b1;
                state_next = S_RC;
            end
            S_RC:
            begin
                cmd.rd_sel = RD_C;
                cmd.cap_b  = 1'b1;
                state_next = S_EX;
            end
            S_EX:
            begin
                cmd.exec   = 1'b1;
                state_next = S_DISP;
            end
            S_DISP:
            begin
                cmd.disp      = 1'b1;
                cmd.div_start = sts.need_div;
                widx_next     = 2'd0;
                if (sts.need_div)
                    state_next = S_DIV;
                else if (sts.wcnt != 2'd0)
                    state_next = S_WR;
                else
                    state_next = S_TOP;
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.div_cap = 1'b1;
                    state_next  = S_WR;
                end
            end
            S_WR:
            begin
                cmd.wr = 1'b1;
                if (widx_reg == sts.wcnt - 2'd1)
                    state_next = S_TOP;
                else
                    widx_next = widx_reg + 2'd1;
            end
            S_TOP:
            begin
                cmd.rd_sel = RD_TOP;
                state_next = S_TOPC;
            end
            S_TOPC:
            begin
                cmd.top_cap = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (!result_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            widx_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            widx_reg  <= widx_next;
        end
    end

    assign instr_stall  = (state_reg != S_IDLE);
    assign result_valid = (state_reg == S_OUT);
endmodule

// ===== design/smeu_dp.sv =====
// ----------------------------------------------------------------------------
// smeu_dp
// stacks, data memory, config registers, decode and execute datapath
// ----------------------------------------------------------------------------
module smeu_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  smeu_pkg::smeu_in_t                  instr,
    output smeu_pkg::smeu_out_t                 result,
    input  logic                                cfg_wen,
    input  logic [smeu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [smeu_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  smeu_pkg::smeu_cmd_t                 cmd,
    output smeu_pkg::smeu_sts_t                 sts
);
    import smeu_pkg::*;

    logic [31:0] dstk [DSTACK_DEPTH];
    logic [15:0] cstk [CSTACK_DEPTH];
    logic [31:0] dmem [MEM_DEPTH];

    logic [7:0]       op_reg;
    logic [31:0]      imm_reg;
    logic [15:0]      pc_reg;
    logic [SP_W-1:0]  sp_reg, sp_next;
    logic [CSP_W-1:0] csp_reg, csp_next;
    logic [12:0]      mem_words_reg, mem_words_next;
    logic [15:0]      code_bytes_reg, code_bytes_next;
    logic [31:0]      a_reg, b_reg;
    logic [31:0]      stk_q, dm_q;
    logic [15:0]      cs_q;
    logic [2:0]       st_reg;
    logic [15:0]      nxt_reg;
    logic [31:0]      top_reg;
    logic [1:0]       wcnt_reg, wcnt_next;
    logic             need_mem_reg, need_mem_next;
    logic             need_div_reg, need_div_next;
    logic             rem_sel_reg;
    logic [DS_AW-1:0] wa_reg [3];
    logic [31:0]      wd_reg [3];

    logic [DS_AW-1:0] stk_raddr;
    logic [31:0]      a, b, c;
    logic [15:0]      off, target;
    logic [16:0]      pc17;
    logic [LIM_W-1:0] lim;
    logic [DS_AW-1:0] sp0, spm1, spm2, spp1;
    logic [2:0]       ex_st, ex_st_fin;
    logic [16:0]      ex_nxt, ex_nxt_fin;
    logic [SP_W-1:0]  ex_nsp;
    logic [CSP_W-1:0] ex_csp;
    logic [1:0]       ex_wc;
    logic [DS_AW-1:0] ex_wa [3];
    logic [31:0]      ex_wd [3];
    logic             ex_mem_rd, ex_mem_wr, ex_cs_wr, ex_div, ex_ok, take;
    logic [31:0]      ex_addr, alu;
    logic [4:0]       sh;
    logic             neg, zero;
    logic             div_done;
    logic [31:0]      div_q, div_r;

    smeu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (b_reg),
        .divisor  (a_reg),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    assign a      = a_reg;
    assign b      = b_reg;
    assign c      = stk_q;
    assign off    = imm_reg[15:0];
    assign target = pc_reg + off;
    assign pc17   = {1'b0, pc_reg};
    assign sh     = a[4:0];
    assign neg    = a[31];
    assign zero   = (a == 32'd0);
    assign sp0    = sp_reg[DS_AW-1:0];
    assign spm1   = DS_AW'(sp_reg - SP_W'(1));
    assign spm2   = DS_AW'(sp_reg - SP_W'(2));
    assign spp1   = DS_AW'(sp_reg + SP_W'(1));
    assign lim    = ({4'd0, mem_words_reg} < LIM_W'(MEM_DEPTH)) ?
                    {4'd0, mem_words_reg} : LIM_W'(MEM_DEPTH);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_A:    stk_raddr = spm1;
            RD_B:    stk_raddr = spm2;
            RD_C:    stk_raddr = DS_AW'(sp_reg - SP_W'(3));
            default: stk_raddr = spm1;
        endcase
    end

    always_comb
    begin
        case (op_reg)
            OP_ADD:  alu = b + a;
            OP_SUB:  alu = b - a;
            OP_MUL:  alu = 32'(b * a);
            OP_AND:  alu = b & a;
            OP_OR:   alu = b | a;
            OP_XOR:  alu = b ^ a;
            OP_SHL:  alu = b << sh;
            OP_SHRA: alu = 32'($signed(b) >>> sh);
            default: alu = b >> sh;
        endcase
    end

    // decode, checks and state updates of one instruction
    always_comb
    begin
        ex_st     = ST_OK;
        ex_nxt    = pc17 + 17'd1;
        ex_nsp    = sp_reg;
        ex_csp    = csp_reg;
        ex_wc     = 2'd0;
        ex_wa[0]  = sp0;
        ex_wa[1]  = sp0;
        ex_wa[2]  = sp0;
        ex_wd[0]  = a;
        ex_wd[1]  = a;
        ex_wd[2]  = a;
        ex_mem_rd = 1'b0;
        ex_mem_wr = 1'b0;
        ex_cs_wr  = 1'b0;
        ex_div    = 1'b0;
        ex_addr   = {16'd0, off};
        take      = 1'b1;
        if (op_reg >= OP_ADD && op_reg <= OP_SHRL)
        begin
            if (op_reg == OP_NEG)
            begin
                if (sp_reg < SP_W'(1))
                    ex_st = ST_UNDER;
                else
                begin
                    ex_wc    = 2'd1;
                    ex_wa[0] = spm1;
                    ex_wd[0] = 32'd0 - a;
                end
            end
            else if (sp_reg < SP_W'(2))
                ex_st = ST_UNDER;
            else if ((op_reg == OP_DIV || op_reg == OP_REM) && zero)
                ex_st = ST_DIV0;
            else
            begin
                ex_wc    = 2'd1;
                ex_wa[0] = spm2;
                ex_wd[0] = alu;
                ex_nsp   = sp_reg - SP_W'(1);
                ex_div   = (op_reg == OP_DIV || op_reg == OP_REM);
            end
        end
        else if (op_reg >= OP_GOTO && op_reg <= OP_BLE)
        begin
            ex_nxt = pc17 + 17'd3;
            if (op_reg == OP_CALL)
            begin
                if (csp_reg >= CSP_W'(CSTACK_DEPTH))
                    ex_st = ST_CALL;
                else
                begin
                    ex_cs_wr = 1'b1;
                    ex_csp   = csp_reg + CSP_W'(1);
                end
            end
            else if (op_reg != OP_GOTO)
            begin
                if (sp_reg < SP_W'(1))
                    ex_st = ST_UNDER;
                else
                    ex_nsp = sp_reg - SP_W'(1);
                case (op_reg)
                    OP_BEQ:  take = zero;
                    OP_BNE:  take = !zero;
                    OP_BLT:  take = neg;
                    OP_BGE:  take = !neg;
                    OP_BGT:  take = !neg && !zero;
                    default: take = neg || zero;
                endcase
            end
            if (take)
                ex_nxt = {1'b0, target};
        end
        else
        begin
            case (op_reg)
                OP_RET:
                begin
                    if (csp_reg == CSP_W'(0))
                        ex_st = ST_CALL;
                    else
                    begin
                        ex_nxt = {1'b0, cs_q};
                        ex_csp = csp_reg - CSP_W'(1);
                    end
                end
                OP_BIPUSH, OP_IPUSH, OP_LPUSH:
                begin
                    if (op_reg == OP_BIPUSH)
                    begin
                        ex_nxt   = pc17 + 17'd2;
                        ex_wd[0] = {{24{imm_reg[7]}}, imm_reg[7:0]};
                    end
                    else if (op_reg == OP_IPUSH)
                    begin
                        ex_nxt   = pc17 + 17'd5;
                        ex_wd[0] = imm_reg;
                    end
                    else
                    begin
                        ex_nxt   = pc17 + 17'd3;
                        ex_wd[0] = {16'd0, off};
                    end
                    if (sp_reg >= SP_W'(DSTACK_DEPTH))
                        ex_st = ST_OVER;
                    else
                    begin
                        ex_wc    = 2'd1;
                        ex_wa[0] = sp0;
                        ex_nsp   = sp_reg + SP_W'(1);
                    end
                end
                OP_POP:
                begin
                    if (sp_reg < SP_W'(1))
                        ex_st = ST_UNDER;
                    else
                        ex_nsp = sp_reg - SP_W'(1);
                end
                OP_DUP:
                begin
                    if (sp_reg < SP_W'(1))
                        ex_st = ST_UNDER;
                    else if (sp_reg >= SP_W'(DSTACK_DEPTH))
                        ex_st = ST_OVER;
                    else
                    begin
                        ex_wc    = 2'd1;
                        ex_wa[0] = sp0;
                        ex_nsp   = sp_reg + SP_W'(1);
                    end
                end
                OP_DUPX1:
                begin
                    if (sp_reg < SP_W'(2))
                        ex_st = ST_UNDER;
                    else if (sp_reg >= SP_W'(DSTACK_DEPTH))
                        ex_st = ST_OVER;
                    else
                    begin
                        ex_wc    = 2'd3;
                        ex_wa[0] = spm2;
                        ex_wa[1] = spm1;
                        ex_wd[1] = b;
                        ex_wa[2] = sp0;
                        ex_nsp   = sp_reg + SP_W'(1);
                    end
                end
                OP_DUP2:
                begin
                    if (sp_reg < SP_W'(2))
                        ex_st = ST_UNDER;
                    else if (sp_reg >= SP_W'(DSTACK_DEPTH - 1))
                        ex_st = ST_OVER;
                    else
                    begin
                        ex_wc    = 2'd2;
                        ex_wa[0] = sp0;
                        ex_wd[0] = b;
                        ex_wa[1] = spp1;
                        ex_nsp   = sp_reg + SP_W'(2);
                    end
                end
                OP_SWAP:
                begin
                    if (sp_reg < SP_W'(2))
                        ex_st = ST_UNDER;
                    else
                    begin
                        ex_wc    = 2'd2;
                        ex_wa[0] = spm2;
                        ex_wa[1] = spm1;
                        ex_wd[1] = b;
                    end
                end
                OP_LOAD:
                begin
                    ex_nxt = pc17 + 17'd3;
                    if (sp_reg >= SP_W'(DSTACK_DEPTH))
                        ex_st = ST_OVER;
                    else if (ex_addr >= 32'(lim))
                        ex_st = ST_ADDR;
                    else
                    begin
                        ex_mem_rd = 1'b1;
                        ex_wc     = 2'd1;
                        ex_wa[0]  = sp0;
                        ex_nsp    = sp_reg + SP_W'(1);
                    end
                end
                OP_STORE:
                begin
                    ex_nxt = pc17 + 17'd3;
                    if (sp_reg < SP_W'(1))
                        ex_st = ST_UNDER;
                    else if (ex_addr >= 32'(lim))
                        ex_st = ST_ADDR;
                    else
                    begin
                        ex_mem_wr = 1'b1;
                        ex_nsp    = sp_reg - SP_W'(1);
                    end
                end
                OP_LDX0, OP_LDX1, OP_LDX2:
                begin
                    ex_addr = b + a;
                    if (sp_reg < SP_W'(2))
                        ex_st = ST_UNDER;
                    else if (ex_addr >= 32'(lim))
                        ex_st = ST_ADDR;
                    else
                    begin
                        ex_mem_rd = 1'b1;
                        ex_wc     = 2'd1;
                        ex_wa[0]  = spm2;
                        ex_nsp    = sp_reg - SP_W'(1);
                    end
                end
                OP_STX0, OP_STX1, OP_STX2:
                begin
                    ex_addr = c + b;
                    if (sp_reg < SP_W'(3))
                        ex_st = ST_UNDER;
                    else if (ex_addr >= 32'(lim))
                        ex_st = ST_ADDR;
                    else
                    begin
                        ex_mem_wr = 1'b1;
                        ex_nsp    = sp_reg - SP_W'(3);
                    end
                end
                OP_NOP:
                begin
                    ex_st = ST_OK;
                end
                OP_HALT:
                begin
                    ex_st = ST_HALT;
                end
                default:
                begin
                    ex_st = ST_UNSUP;
                end
            endcase
        end

        ex_ok      = (ex_st < ST_UNDER);
        ex_st_fin  = ex_st;
        ex_nxt_fin = ex_nxt;
        if (!ex_ok)
            ex_nxt_fin = pc17;
        else if (ex_st == ST_OK && ex_nxt >= {1'b0, code_bytes_reg})
            ex_st_fin = ST_HALT;
    end

    // configuration registers
    always_comb
    begin
        mem_words_next  = mem_words_reg;
        code_bytes_next = code_bytes_reg;
        if (cfg_wen)
        begin
            case (cfg_index)
                CFG_MEM_WORDS:  mem_words_next  = cfg_data[12:0];
                CFG_CODE_BYTES: code_bytes_next = cfg_data;
                default:        mem_words_next  = mem_words_reg;
            endcase
        end
    end

    always_comb
    begin
        sp_next       = sp_reg;
        csp_next      = csp_reg;
        wcnt_next     = wcnt_reg;
        need_mem_next = need_mem_reg;
        need_div_next = need_div_reg;
        if (cmd.exec)
        begin
            if (ex_ok)
            begin
                sp_next  = ex_nsp;
                csp_next = ex_csp;
            end
            wcnt_next     = ex_ok ? ex_wc : 2'd0;
            need_mem_next = ex_ok && ex_mem_rd;
            need_div_next = ex_ok && ex_div;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg         <= '0;
            csp_reg        <= '0;
            mem_words_reg  <= 13'd4096;
            code_bytes_reg <= 16'hffff;
            wcnt_reg       <= 2'd0;
            need_mem_reg   <= 1'b0;
            need_div_reg   <= 1'b0;
        end
        else
        begin
            sp_reg         <= sp_next;
            csp_reg        <= csp_next;
            mem_words_reg  <= mem_words_next;
            code_bytes_reg <= code_bytes_next;
            wcnt_reg       <= wcnt_next;
            need_mem_reg   <= need_mem_next;
            need_div_reg   <= need_div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= instr.opcode;
            imm_reg <= instr.immediate;
            pc_reg  <= instr.pc;
        end
        if (cmd.cap_a)
            a_reg <= stk_q;
        if (cmd.cap_b)
            b_reg <= stk_q;
        if (cmd.exec)
        begin
            st_reg      <= ex_st_fin;
            nxt_reg     <= ex_nxt_fin[15:0];
            rem_sel_reg <= (op_reg == OP_REM);
            for (int i = 0; i < 3; i++)
            begin
                wa_reg[i] <= ex_wa[i];
                wd_reg[i] <= ex_wd[i];
            end
        end
        if (cmd.disp && need_mem_reg)
            wd_reg[0] <= dm_q;
        if (cmd.div_cap)
            wd_reg[0] <= rem_sel_reg ? div_r : div_q;
        if (cmd.top_cap)
            top_reg <= (sp_reg == SP_W'(0)) ? 32'd0 : stk_q;
    end

    // data stack: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
            dstk[wa_reg[cmd.widx]] <= wd_reg[cmd.widx];
        stk_q <= dstk[stk_raddr];
    end

    // call stack
    always_ff @(posedge clk)
    begin
        if (cmd.exec && ex_ok && ex_cs_wr)
            cstk[csp_reg[CS_AW-1:0]] <= 16'(pc_reg + 16'd3);
        cs_q <= cstk[CS_AW'(csp_reg - CSP_W'(1))];
    end

    // data memory
    always_ff @(posedge clk)
    begin
        if (cmd.exec && ex_ok && ex_mem_wr)
            dmem[ex_addr[MEM_AW-1:0]] <= a;
        dm_q <= dmem[ex_addr[MEM_AW-1:0]];
    end

    assign sts.need_div = need_div_reg;
    assign sts.wcnt     = wcnt_reg;
    assign sts.div_done = div_done;

    assign result.status      = st_reg;
    assign result.next_pc     = nxt_reg;
    assign result.top_value   = top_reg;
    assign result.stack_depth = 7'(sp_reg);
endmodule

// ===== design/stack_machine_execute_unit_core.sv =====
// ----------------------------------------------------------------------------
// stack_machine_execute_unit_core
// one instruction at a time: after the instruction word is taken come operand reads,
// execute, div/rem divide, n = 0..3 stack writes, top read, then the result word
// the next instruction word is taken the cycle after the result word is taken
// operand and top reads go in turn through the single data stack read port
// reset: stacks empty, mem_words 4096, code_bytes 65535; stores undefined
// ----------------------------------------------------------------------------
module stack_machine_execute_unit_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             instr_valid,
    output logic                             instr_stall,
    input  smeu_pkg::smeu_in_t               instr,
    output logic                             result_valid,
    input  logic                             result_stall,
    output smeu_pkg::smeu_out_t              result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [smeu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [smeu_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import smeu_pkg::*;

`include "stack_machine_execute_unit_core_defines.svh"

    smeu_cmd_t cmd;
    smeu_sts_t sts;

    assign cfg_ready = 1'b1;

    smeu_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr_valid  (instr_valid),
        .instr_stall  (instr_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    smeu_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .instr     (instr),
        .result    (result),
        .cfg_wen   (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    `SMEU_ASSERT_IMP(a_one_in_flight, result_valid, instr_stall, "word taken while result pending")
    `SMEU_ASSERT_IMP(a_empty_top_zero, result_valid && result.stack_depth == 7'd0,
        result.top_value == 32'd0, "empty stack with nonzero top")
    `SMEU_ASSERT_IMP(a_depth_range, result_valid, result.stack_depth <= 7'(DSTACK_DEPTH),
        "stack depth beyond capacity")
    `SMEU_ASSERT_NXT(a_no_early_result, instr_valid && !instr_stall, !result_valid,
        "result in the cycle after accept")
endmodule

// ===== tb/sv/tb_stack_machine_execute_unit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stack_machine_execute_unit_core
// self-checking bench for the stack machine execute unit: a local model of the
// stacks and data memory predicts every result word, directed tests hit the
// opcode set, stack and call limits, then random instruction traffic runs under
// several register settings with random idle and stall on both channels
// ----------------------------------------------------------------------------
module tb_stack_machine_execute_unit_core;
    import smeu_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      instr_valid = 1'b0;
    logic      instr_stall;
    smeu_in_t  instr = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    smeu_out_t result;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [31:0] dstk [DSTACK_DEPTH];
    int          dsp;
    logic [15:0] cstk [CSTACK_DEPTH];
    int          csp;
    logic [31:0] dmem [MEM_DEPTH];
    bit          dmem_wr [MEM_DEPTH];
    int unsigned mem_words_r;
    int unsigned code_bytes_r;

    smeu_out_t expected_results [$];
    int  fails;
    int  sent_count;
    int  idle_pct;
    int  stall_pct;
    int  hold_left;
    longint cycles;

    stack_machine_execute_unit_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr_valid  (instr_valid),
        .instr_stall  (instr_stall),
        .instr        (instr),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic int unsigned mem_limit();
        return (mem_words_r < MEM_DEPTH) ? mem_words_r : MEM_DEPTH;
    endfunction

    function automatic smeu_out_t predict_step(input smeu_in_t it);
        logic [7:0]  op;
        logic [31:0] imm;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] addr;
        logic [15:0] off;
        logic [31:0] nxt;
        logic [2:0]  st;
        int unsigned lim;
        bit          take;
        smeu_out_t   r;
        op   = it.opcode;
        imm  = it.immediate;
        off  = imm[15:0];
        nxt  = {16'h0, it.pc} + 32'd1;
        st   = ST_OK;
        lim  = mem_limit();
        take = 1'b1;
        if (op >= OP_ADD && op <= OP_SHRL)
        begin
            if (op == OP_NEG)
            begin
                if (dsp < 1)
                    st = ST_UNDER;
                else
                    dstk[dsp-1] = 32'd0 - dstk[dsp-1];
            end
            else if (dsp < 2)
                st = ST_UNDER;
            else
            begin
                a = dstk[dsp-1];
                b = dstk[dsp-2];
                if ((op == OP_DIV || op == OP_REM) && a == 32'd0)
                    st = ST_DIV0;
                else
                begin
                    case (op)
                        OP_ADD:  dstk[dsp-2] = b + a;
                        OP_SUB:  dstk[dsp-2] = b - a;
                        OP_MUL:  dstk[dsp-2] = b * a;
                        OP_DIV:  dstk[dsp-2] = b / a;
                        OP_REM:  dstk[dsp-2] = b % a;
                        OP_AND:  dstk[dsp-2] = b & a;
                        OP_OR:   dstk[dsp-2] = b | a;
                        OP_XOR:  dstk[dsp-2] = b ^ a;
                        OP_SHL:  dstk[dsp-2] = b << a[4:0];
                        OP_SHRA: dstk[dsp-2] = $signed(b) >>> a[4:0];
                        default: dstk[dsp-2] = b >> a[4:0];
                    endcase
                    dsp--;
                end
            end
        end
        else if (op >= OP_GOTO && op <= OP_BLE)
        begin
            nxt = {16'h0, it.pc} + 32'd3;
            if (op == OP_CALL)
            begin
                if (csp >= CSTACK_DEPTH)
                    st = ST_CALL;
                else
                begin
                    cstk[csp] = it.pc + 16'd3;
                    csp++;
                end
            end
            else if (op != OP_GOTO)
            begin
                if (dsp < 1)
                    st = ST_UNDER;
                else
                begin
                    dsp--;
                    a = dstk[dsp];
                    case (op)
                        OP_BEQ:  take = (a == 32'd0);
                        OP_BNE:  take = (a != 32'd0);
                        OP_BLT:  take = a[31];
                        OP_BGE:  take = !a[31];
                        OP_BGT:  take = !a[31] && a != 32'd0;
                        default: take = a[31] || a == 32'd0;
                    endcase
                end
            end
            if (st == ST_OK && take)
                nxt = {16'h0, 16'(it.pc + off)};
        end
        else
        begin
            case (op)
                OP_RET:
                begin
                    if (csp == 0)
                        st = ST_CALL;
                    else
                    begin
                        csp--;
                        nxt = {16'h0, cstk[csp]};
                    end
                end
                OP_BIPUSH, OP_IPUSH, OP_LPUSH:
                begin
                    if (dsp >= DSTACK_DEPTH)
                        st = ST_OVER;
                    else
                    begin
                        if (op == OP_BIPUSH)
                        begin
                            a = {{24{imm[7]}}, imm[7:0]};
                            nxt = {16'h0, it.pc} + 32'd2;
                        end
                        else if (op == OP_IPUSH)
                        begin
                            a = imm;
                            nxt = {16'h0, it.pc} + 32'd5;
                        end
                        else
                        begin
                            a = {16'h0, off};
                            nxt = {16'h0, it.pc} + 32'd3;
                        end
                        dstk[dsp] = a;
                        dsp++;
                    end
                end
                OP_POP:
                begin
                    if (dsp < 1)
                        st = ST_UNDER;
                    else
                        dsp--;
                end
                OP_DUP:
                begin
                    if (dsp < 1)
                        st = ST_UNDER;
                    else if (dsp >= DSTACK_DEPTH)
                        st = ST_OVER;
                    else
                    begin
                        dstk[dsp] = dstk[dsp-1];
                        dsp++;
                    end
                end
                OP_DUPX1, OP_DUP2, OP_SWAP:
                begin
                    if (dsp < 2)
                        st = ST_UNDER;
                    else
                    begin
                        a = dstk[dsp-1];
                        b = dstk[dsp-2];
                        if (op == OP_DUPX1)
                        begin
                            if (dsp >= DSTACK_DEPTH)
                                st = ST_OVER;
                            else
                            begin
                                dstk[dsp-2] = a;
                                dstk[dsp-1] = b;
                                dstk[dsp]   = a;
                                dsp++;
                            end
                        end
                        else if (op == OP_DUP2)
                        begin
                            if (dsp + 2 > DSTACK_DEPTH)
                                st = ST_OVER;
                            else
                            begin
                                dstk[dsp]   = b;
                                dstk[dsp+1] = a;
                                dsp += 2;
                            end
                        end
                        else
                        begin
                            dstk[dsp-2] = a;
                            dstk[dsp-1] = b;
                        end
                    end
                end
                OP_LOAD:
                begin
                    nxt = {16'h0, it.pc} + 32'd3;
                    if (dsp >= DSTACK_DEPTH)
                        st = ST_OVER;
                    else if (off >= lim)
                        st = ST_ADDR;
                    else
                    begin
                        dstk[dsp] = dmem[off[MEM_AW-1:0]];
                        dsp++;
                    end
                end
                OP_STORE:
                begin
                    nxt = {16'h0, it.pc} + 32'd3;
                    if (dsp < 1)
                        st = ST_UNDER;
                    else if (off >= lim)
                        st = ST_ADDR;
                    else
                    begin
                        dsp--;
                        dmem[off[MEM_AW-1:0]]    = dstk[dsp];
                        dmem_wr[off[MEM_AW-1:0]] = 1'b1;
                    end
                end
                OP_LDX0, OP_LDX1, OP_LDX2:
                begin
                    if (dsp < 2)
                        st = ST_UNDER;
                    else
                    begin
                        addr = dstk[dsp-2] + dstk[dsp-1];
                        if (addr >= lim)
                            st = ST_ADDR;
                        else
                        begin
                            dsp--;
                            dstk[dsp-1] = dmem[addr[MEM_AW-1:0]];
                        end
                    end
                end
                OP_STX0, OP_STX1, OP_STX2:
                begin
                    if (dsp < 3)
                        st = ST_UNDER;
                    else
                    begin
                        addr = dstk[dsp-3] + dstk[dsp-2];
                        if (addr >= lim)
                            st = ST_ADDR;
                        else
                        begin
                            dmem[addr[MEM_AW-1:0]]    = dstk[dsp-1];
                            dmem_wr[addr[MEM_AW-1:0]] = 1'b1;
                            dsp -= 3;
                        end
                    end
                end
                OP_NOP: ;
                OP_HALT: st = ST_HALT;
                default: st = ST_UNSUP;
            endcase
        end
        if (st >= ST_UNDER)
            nxt = {16'h0, it.pc};
        else if (st == ST_OK && nxt >= code_bytes_r)
            st = ST_HALT;
        r.status      = st;
        r.next_pc     = nxt[15:0];
        r.top_value   = (dsp > 0) ? dstk[dsp-1] : 32'd0;
        r.stack_depth = dsp[6:0];
        return r;
    endfunction

    // loads of never-written words are turned into nop
    task automatic send_word(input logic [7:0] op, input logic [31:0] imm,
                             input logic [15:0] pc);
        smeu_in_t    it;
        logic [31:0] ea;
        int unsigned lim;
        it.opcode    = op;
        it.immediate = imm;
        it.pc        = pc;
        lim          = mem_limit();
        if (op == OP_LOAD && dsp < DSTACK_DEPTH && imm[15:0] < lim
            && !dmem_wr[imm[MEM_AW-1:0]])
            it.opcode = OP_NOP;
        if ((op == OP_LDX0 || op == OP_LDX1 || op == OP_LDX2) && dsp >= 2)
        begin
            ea = dstk[dsp-2] + dstk[dsp-1];
            if (ea < lim && !dmem_wr[ea[MEM_AW-1:0]])
                it.opcode = OP_NOP;
        end
        instr_valid <= 1'b1;
        instr       <= it;
        do
            @(posedge clk);
        while (instr_stall);
        expected_results.push_back(predict_step(it));
        sent_count++;
        if ($urandom_range(99) < idle_pct)
        begin
            instr_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        instr_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_MEM_WORDS)
            mem_words_r = val & 32'h1fff;
        else if (idx == CFG_CODE_BYTES)
            code_bytes_r = val & 32'hffff;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(6))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'hffffffff;
            3:       return 32'h7fffffff;
            4:       return 32'h80000000;
            5:       return $urandom_range(40);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rnd_pc();
        return 16'($urandom_range(65535));
    endfunction

    task automatic test_alu_ops();
        logic [7:0] op;
        send_word(OP_ADD, 32'd0, 16'h0000);
        send_word(OP_NEG, 32'd0, 16'h0001);
        send_word(OP_IPUSH, 32'h80000000, 16'h0010);
        send_word(OP_IPUSH, 32'h7fffffff, 16'h0015);
        send_word(OP_ADD, 32'd0, 16'h001a);
        send_word(OP_NEG, 32'd0, 16'h001b);
        for (op = OP_SUB; op <= OP_SHRL; op++)
        begin
            if (op == OP_NEG)
                continue;
            send_word(OP_IPUSH, 32'hf0000005, 16'h0100);
            send_word(OP_BIPUSH, (op == OP_DIV) ? 32'h00000000 : 32'h000000a3, 16'h0105);
            send_word(op, 32'd0, 16'h0107);
        end
        send_word(OP_BIPUSH, 32'h0000007f, 16'h0200);
        send_word(OP_REM, 32'd0, 16'h0202);
        send_word(OP_BIPUSH, 32'd0, 16'h0203);
        send_word(OP_REM, 32'd0, 16'h0205);
        drain();
    endtask

    task automatic test_control_flow();
        send_word(OP_GOTO, 32'h0000fff0, 16'h0008);
        send_word(OP_CALL, 32'h00000100, 16'hfffe);
        send_word(OP_RET, 32'd0, 16'h1234);
        send_word(OP_RET, 32'd0, 16'h1234);
        send_word(OP_BEQ, 32'd8, 16'h0040);
        for (int k = 0; k < 6; k++)
        begin
            send_word(OP_IPUSH, (k % 3 == 0) ? 32'd0 : (k % 3 == 1) ? 32'hffffff00 : 32'd9,
                      16'h0300);
            send_word(8'(OP_BEQ + k), 32'h0000ff00, 16'h0305);
        end
        send_word(OP_NOP, 32'hffffffff, 16'hffff);
        send_word(OP_HALT, 32'd0, 16'h0050);
        send_word(8'h20, 32'd0, 16'h0051);
        send_word(8'h52, 32'd0, 16'h0052);
        send_word(8'h68, 32'd0, 16'h0053);
        send_word(8'hf1, 32'd0, 16'h0054);
        send_word(8'hff, 32'd0, 16'h0055);
        drain();
    endtask

    task automatic test_memory_access();
        send_word(OP_STORE, 32'd5, 16'h0400);
        send_word(OP_IPUSH, 32'hdeadbeef, 16'h0400);
        send_word(OP_STORE, 32'h00000fff, 16'h0405);
        send_word(OP_LOAD, 32'h00000fff, 16'h0408);
        send_word(OP_LOAD, 32'h00001000, 16'h040b);
        send_word(OP_STORE, 32'h0000ffff, 16'h040e);
        send_word(OP_IPUSH, 32'hfffffff0, 16'h0411);
        send_word(OP_LPUSH, 32'h00000013, 16'h0416);
        send_word(OP_IPUSH, 32'h12345678, 16'h0419);
        send_word(OP_STX1, 32'd0, 16'h041e);
        send_word(OP_IPUSH, 32'hfffffff0, 16'h041f);
        send_word(OP_LPUSH, 32'h00000013, 16'h0424);
        send_word(OP_LDX2, 32'd0, 16'h0427);
        send_word(OP_LPUSH, 32'h0000ffff, 16'h0428);
        send_word(OP_LDX0, 32'd0, 16'h042b);
        drain();
    endtask

    task automatic test_stack_limits();
        while (dsp > 0)
            send_word(OP_POP, 32'd0, 16'h0500);
        send_word(OP_POP, 32'd0, 16'h0500);
        send_word(OP_DUP, 32'd0, 16'h0501);
        send_word(OP_SWAP, 32'd0, 16'h0502);
        send_word(OP_STX0, 32'd0, 16'h0503);
        for (int k = 0; k < DSTACK_DEPTH - 1; k++)
            send_word(OP_BIPUSH, $urandom, 16'h0510);
        send_word(OP_DUP2, 32'd0, 16'h0512);
        send_word(OP_DUPX1, 32'd0, 16'h0513);
        send_word(OP_LPUSH, 32'h0000abcd, 16'h0514);
        send_word(OP_DUP, 32'd0, 16'h0517);
        send_word(OP_LOAD, 32'd0, 16'h0518);
        send_word(OP_SWAP, 32'd0, 16'h051b);
        while (dsp > 0)
            send_word(OP_POP, 32'd0, 16'h051c);
        drain();
    endtask

    task automatic test_call_limits();
        for (int k = 0; k <= CSTACK_DEPTH; k++)
            send_word(OP_CALL, 32'h00000040, 16'(16'h0600 + 16'(k * 4)));
        for (int k = 0; k <= CSTACK_DEPTH; k++)
            send_word(OP_RET, 32'd0, 16'h0700);
        drain();
    endtask

    task automatic random_traffic(input int n);
        int          stop;
        int          kind;
        logic [31:0] addr;
        logic [31:0] base;
        stop = sent_count + n;
        while (sent_count < stop)
        begin
            kind = $urandom_range(99);
            if (dsp > 56)
                send_word(OP_POP, rnd_val(), rnd_pc());
            else if (kind < 12)
                send_word(8'($urandom), $urandom, rnd_pc());
            else if (kind < 35)
            begin
                send_word(OP_IPUSH, rnd_val(), rnd_pc());
                send_word($urandom_range(1) ? OP_BIPUSH : OP_IPUSH, rnd_val(), rnd_pc());
                send_word(8'($urandom_range(OP_ADD, OP_SHRL)), $urandom, rnd_pc());
            end
            else if (kind < 60)
            begin
                addr = $urandom_range(3) == 0 ? $urandom_range(65535)
                                               : $urandom_range(mem_limit() + 3);
                base = $urandom_range(7) == 0 ? 32'hffffff00 : $urandom_range(addr);
                send_word(OP_IPUSH, base, rnd_pc());
                send_word(OP_IPUSH, addr - base, rnd_pc());
                send_word(OP_IPUSH, rnd_val(), rnd_pc());
                send_word(8'(OP_STX0 + 2 * $urandom_range(2)), 32'd0, rnd_pc());
                send_word(OP_IPUSH, base, rnd_pc());
                send_word(OP_IPUSH, addr - base, rnd_pc());
                send_word(8'(OP_LDX0 + 2 * $urandom_range(2)), 32'd0, rnd_pc());
                send_word(OP_STORE, {16'($urandom_range(65535)), addr[15:0]}, rnd_pc());
                send_word(OP_LOAD, {16'($urandom), addr[15:0]}, rnd_pc());
            end
            else if (kind < 72)
            begin
                send_word(OP_IPUSH, rnd_val(), rnd_pc());
                send_word(8'($urandom_range(OP_BEQ, OP_BLE)), $urandom, rnd_pc());
            end
            else if (kind < 82)
            begin
                send_word(OP_CALL, $urandom, rnd_pc());
                if ($urandom_range(1))
                    send_word(OP_CALL, $urandom, rnd_pc());
                send_word(OP_GOTO, $urandom, rnd_pc());
                send_word(OP_RET, $urandom, rnd_pc());
            end
            else if (kind < 94)
                send_word(8'($urandom_range(OP_POP, OP_SWAP)), $urandom, rnd_pc());
            else
                send_word($urandom_range(1) ? OP_LPUSH : OP_HALT, $urandom, rnd_pc());
        end
        drain();
    endtask

    task automatic test_backpressure(input int n);
        hold_left <= 400;
        @(posedge clk);
        random_traffic(n);
    endtask

    task automatic run_phase(input int mw, input int cb, input int idle_p,
                             input int stall_p, input int n);
        write_reg(CFG_MEM_WORDS, mw);
        write_reg(CFG_CODE_BYTES, cb);
        idle_pct  = idle_p;
        stall_pct = stall_p;
        random_traffic(n);
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // result word checker
    initial
    begin
        smeu_out_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    fails++;
                    $display("%0t unexpected result word %h", $time, result);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.status !== result.status)
                    begin
                        fails++;
                        $display("%0t status exp %0d got %0d", $time, want.status,
                                 result.status);
                    end
                    if (want.next_pc !== result.next_pc)
                    begin
                        fails++;
                        $display("%0t next_pc exp %h got %h", $time, want.next_pc,
                                 result.next_pc);
                    end
                    if (want.top_value !== result.top_value)
                    begin
                        fails++;
                        $display("%0t top_value exp %h got %h", $time, want.top_value,
                                 result.top_value);
                    end
                    if (want.stack_depth !== result.stack_depth)
                    begin
                        fails++;
                        $display("%0t stack_depth exp %0d got %0d", $time,
                                 want.stack_depth, result.stack_depth);
                    end
                end
            end
            result_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        fails        = 0;
        sent_count   = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_left    = 0;
        dsp          = 0;
        csp          = 0;
        mem_words_r  = 4096;
        code_bytes_r = 65535;
        for (int k = 0; k < MEM_DEPTH; k++)
            dmem_wr[k] = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_alu_ops();
        test_control_flow();
        test_memory_access();
        idle_pct  = 30;
        stall_pct = 30;
        test_stack_limits();
        test_call_limits();
        run_phase(4096, 65535, 0, 0, 320);
        run_phase(16, 40000, 57, 0, 250);
        run_phase(0, 1, 0, 57, 130);
        run_phase(4095, 200, 30, 30, 250);
        run_phase(100, 65535, 0, 0, 160);
        test_backpressure(60);
        run_phase(4096, 65534, 30, 30, 200);
        drain();
        if (fails == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
